@@ sv/drdf_pkg.sv @@
// drdf_pkg: types, constants and helpers of the detection row decode filter.
// No dependencies; used by every module of the block.
`default_nettype none

package drdf_pkg;

    localparam int MAX_CLASSES = 128;
    localparam int MAX_ROWS    = 16384;
    localparam int VAL_W       = 32;
    localparam int CLASS_W     = 7;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int POS_W       = 8;
    localparam int WIDE_W      = VAL_W + 2;

    // configuration register indexes
    localparam logic [2:0] CFG_CORNER_MODE  = 3'd0;
    localparam logic [2:0] CFG_CLASS_COUNT  = 3'd1;
    localparam logic [2:0] CFG_SCORE_THRESH = 3'd2;
    localparam logic [2:0] CFG_MODEL_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_MODEL_HEIGHT = 3'd4;
    localparam int         CFG_DATA_W       = 17;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    row_last;
        logic                    frame_end;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] left;
        logic signed [VAL_W-1:0] top;
        logic signed [VAL_W-1:0] right;
        logic signed [VAL_W-1:0] bottom;
        logic signed [VAL_W-1:0] best_score;
        logic [CLASS_W-1:0]      label;
        logic [ROW_W-1:0]        row_index;
    } t_out;

    typedef struct packed {
        logic        corner_mode;
        logic [7:0]  class_count;
        logic [16:0] min_score;
        logic [12:0] model_width;
        logic [12:0] model_height;
    } t_cfg;

    // row state as it stands after the row's last element
    typedef struct packed {
        logic signed [VAL_W-1:0] b0;
        logic signed [VAL_W-1:0] b1;
        logic signed [VAL_W-1:0] b2;
        logic signed [VAL_W-1:0] b3;
        logic signed [VAL_W-1:0] score;
        logic [CLASS_W-1:0]      label;
        logic                    class_valid;
        logic [ROW_W-1:0]        row_index;
    } t_row_snap;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh7FFF_FFFF);
        lo = -WIDE_W'(64'sh8000_0000);
        if (v > hi) begin
            return VAL_W'(hi);
        end else if (v < lo) begin
            return VAL_W'(lo);
        end else begin
            return v[VAL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/drdf_row_accum.sv @@
// drdf_row_accum: per-row state (box elements, best class, positions, row count).
// Depends on drdf_pkg.
`default_nettype none

module drdf_row_accum (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire drdf_pkg::t_in       i_item,
    input  wire drdf_pkg::t_cfg      i_cfg,
    output drdf_pkg::t_row_snap      o_snap
);

    logic [drdf_pkg::POS_W-1:0]        r_pos;
    logic signed [drdf_pkg::VAL_W-1:0] r_box [4];
    logic signed [drdf_pkg::VAL_W-1:0] r_score;
    logic [drdf_pkg::CLASS_W-1:0]      r_class;
    logic                              r_class_valid;
    logic [drdf_pkg::ROW_W-1:0]        r_row_cnt;

    logic signed [drdf_pkg::VAL_W-1:0] n_box [4];
    logic signed [drdf_pkg::VAL_W-1:0] n_score;
    logic [drdf_pkg::CLASS_W-1:0]      n_class;
    logic                              n_class_valid;
    logic [drdf_pkg::POS_W-1:0]        cls_idx;
    logic signed [drdf_pkg::VAL_W-1:0] v;

    assign v       = i_item.value;
    assign cls_idx = r_pos - drdf_pkg::POS_W'(4);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_box[k] = r_box[k];
        end
        n_score       = r_score;
        n_class       = r_class;
        n_class_valid = r_class_valid;
        if (r_pos < drdf_pkg::POS_W'(4)) begin
            n_box[r_pos[1:0]] = v;
        end else if (i_cfg.corner_mode) begin
            if (r_pos == drdf_pkg::POS_W'(4)) begin
                n_score = v;
            end else if (r_pos == drdf_pkg::POS_W'(5)) begin
                // truncation toward zero: negative id only from -1.0 down
                if (v <= -drdf_pkg::VAL_W'(65536)) begin
                    n_class_valid = 1'b0;
                    n_class       = '1;
                end else if (v >= drdf_pkg::VAL_W'(drdf_pkg::MAX_CLASSES * 65536)) begin
                    n_class_valid = 1'b1;
                    n_class       = drdf_pkg::CLASS_W'(drdf_pkg::MAX_CLASSES - 1);
                end else if (v[drdf_pkg::VAL_W-1]) begin
                    n_class_valid = 1'b1;
                    n_class       = '0;
                end else begin
                    n_class_valid = 1'b1;
                    n_class       = v[16 +: drdf_pkg::CLASS_W];
                end
            end
        end else begin
            if (cls_idx < i_cfg.class_count &&
                {1'b0, cls_idx} < 9'(drdf_pkg::MAX_CLASSES) &&
                v > r_score) begin
                n_score       = v;
                n_class       = cls_idx[drdf_pkg::CLASS_W-1:0];
                n_class_valid = 1'b1;
            end
        end
    end

    always_comb begin
        o_snap.b0          = n_box[0];
        o_snap.b1          = n_box[1];
        o_snap.b2          = n_box[2];
        o_snap.b3          = n_box[3];
        o_snap.score       = n_score;
        o_snap.label       = n_class;
        o_snap.class_valid = n_class_valid;
        o_snap.row_index   = r_row_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_score       <= '0;
            r_class       <= '1;
            r_class_valid <= 1'b0;
            r_row_cnt     <= '0;
            for (int k = 0; k < 4; k++) begin
                r_box[k] <= '0;
            end
        end else if (i_step) begin
            if (i_item.row_last) begin
                r_pos         <= '0;
                r_score       <= '0;
                r_class       <= '1;
                r_class_valid <= 1'b0;
                for (int k = 0; k < 4; k++) begin
                    r_box[k] <= '0;
                end
                if (i_item.frame_end) begin
                    r_row_cnt <= '0;
                end else begin
                    r_row_cnt <= r_row_cnt + drdf_pkg::ROW_W'(1);
                end
            end else begin
                if (r_pos != '1) begin
                    r_pos <= r_pos + drdf_pkg::POS_W'(1);
                end
                r_score       <= n_score;
                r_class       <= n_class;
                r_class_valid <= n_class_valid;
                for (int k = 0; k < 4; k++) begin
                    r_box[k] <= n_box[k];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/drdf_box_decode.sv @@
// drdf_box_decode: corner decode, clamping and score filter of a finished row.
// Depends on drdf_pkg.
`default_nettype none

module drdf_box_decode (
    input  wire drdf_pkg::t_row_snap i_snap,
    input  wire drdf_pkg::t_cfg      i_cfg,
    output drdf_pkg::t_out           o_result,
    output logic                     o_keep
);

    localparam int W = drdf_pkg::WIDE_W;

    logic signed [W-1:0] hw;
    logic signed [W-1:0] hh;
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] x2;
    logic signed [W-1:0] y2;
    logic signed [W-1:0] wlim;
    logic signed [W-1:0] hlim;
    logic signed [W-1:0] x1_c;
    logic signed [W-1:0] y1_c;
    logic signed [W-1:0] x2_c;
    logic signed [W-1:0] y2_c;
    logic signed [drdf_pkg::VAL_W-1:0] thr;

    assign wlim = W'({i_cfg.model_width, 16'b0});
    assign hlim = W'({i_cfg.model_height, 16'b0});

    always_comb begin
        // floor halving of the size
        hw = W'(i_snap.b2) >>> 1;
        hh = W'(i_snap.b3) >>> 1;
        if (i_cfg.corner_mode) begin
            x1 = W'(i_snap.b0);
            y1 = W'(i_snap.b1);
            x2 = W'(i_snap.b2);
            y2 = W'(i_snap.b3);
        end else begin
            x1 = W'(i_snap.b0) - hw;
            x2 = W'(i_snap.b0) + hw;
            y1 = W'(i_snap.b1) - hh;
            y2 = W'(i_snap.b1) + hh;
        end
        x1_c = (x1 < 0) ? '0 : x1;
        y1_c = (y1 < 0) ? '0 : y1;
        x2_c = (x2 > wlim) ? wlim : x2;
        y2_c = (y2 > hlim) ? hlim : y2;
    end

    assign thr = drdf_pkg::VAL_W'(i_cfg.min_score);

    always_comb begin
        o_result.left       = drdf_pkg::sat32(x1_c);
        o_result.top        = drdf_pkg::sat32(y1_c);
        o_result.right      = drdf_pkg::sat32(x2_c);
        o_result.bottom     = drdf_pkg::sat32(y2_c);
        o_result.best_score = i_snap.score;
        o_result.label      = i_snap.label;
        o_result.row_index  = i_snap.row_index;
        o_keep              = i_snap.class_valid && (i_snap.score >= thr);
    end

endmodule

`default_nettype wire

@@ sv/detection_row_decode_filter_core.sv @@
// Detection row decode filter, top level: input register, row accumulator,
// box decode and result register. Depends on drdf_pkg, drdf_row_accum, drdf_box_decode.
// A row's result is registered in the result register when its last element leaves the input register.
// Throughput: one element per cycle; an element leaves the input register each cycle
// the result register is empty or being taken.
// Reset (i_rst_n low, synchronous): pipeline empty, row state cleared, configuration registers default.
`default_nettype none

module detection_row_decode_filter_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire drdf_pkg::t_in      i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output drdf_pkg::t_out          o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [drdf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    drdf_pkg::t_cfg      r_cfg;
    logic                r_in_valid;
    drdf_pkg::t_in       r_in;
    logic                r_out_valid;
    drdf_pkg::t_out      r_out;

    logic                out_free;
    logic                step;
    logic                in_take;
    logic                keep;
    drdf_pkg::t_row_snap snap;
    drdf_pkg::t_out      result;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.corner_mode  <= 1'b0;
            r_cfg.class_count  <= 8'd80;
            r_cfg.min_score    <= 17'd16384;
            r_cfg.model_width  <= 13'd640;
            r_cfg.model_height <= 13'd640;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                drdf_pkg::CFG_CORNER_MODE:  r_cfg.corner_mode  <= i_cfg_data[0];
                drdf_pkg::CFG_CLASS_COUNT:  r_cfg.class_count  <= i_cfg_data[7:0];
                drdf_pkg::CFG_SCORE_THRESH: r_cfg.min_score    <= i_cfg_data;
                drdf_pkg::CFG_MODEL_WIDTH:  r_cfg.model_width  <= i_cfg_data[12:0];
                drdf_pkg::CFG_MODEL_HEIGHT: r_cfg.model_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    drdf_row_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_snap  (snap)
    );

    drdf_box_decode u_decode (
        .i_snap   (snap),
        .i_cfg    (r_cfg),
        .o_result (result),
        .o_keep   (keep)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= r_in.row_last && keep;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ sv/drdf_checker.sv @@
// drdf_checker: port-level assertions for the detection row decode filter,
// bound to detection_row_decode_filter_core. Depends on drdf_pkg.
`default_nettype none

module drdf_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_out_valid,
    input wire logic           i_out_ready,
    input wire drdf_pkg::t_out i_out_data
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    // nothing leaves straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // low corners are clamped at zero
    a_low_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_data.left[31] && !i_out_data.top[31])
        else $error("negative low corner");

    // kept scores meet a non-negative threshold
    a_score_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_data.best_score[31])
        else $error("negative score passed the filter");

endmodule

bind detection_row_decode_filter_core drdf_checker u_drdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire
